### sv/vtffa_pkg.sv
// ----------------------------------------------------------------------------
// vtffa_pkg
// Shared types, command codes and a helper function for the vehicle type allocator.
// ----------------------------------------------------------------------------
package vtffa_pkg;

  // Field widths fixed by the request format
  localparam int CMD_W     = 3;
  localparam int TYPE_W    = 3;
  localparam int SITE_W    = 10;
  localparam int CAP_W     = 20;
  localparam int CNT_IN_W  = 16;
  localparam int MASK_W    = 8;
  localparam int LOAD_W    = 28;
  localparam int FRAC_BITS = 8;

  // Parameter defaults
  localparam int DEF_NUM_TYPES  = 8;
  localparam int DEF_NUM_SITES  = 1024;
  localparam int DEF_COUNT_BITS = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_TYPE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_MASK = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESERVE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [TYPE_W-1:0]   type_index;
    logic [SITE_W-1:0]   site_index;
    logic [CAP_W-1:0]    capacity_value;
    logic [CNT_IN_W-1:0] count_value;
    logic [MASK_W-1:0]   forbid_mask;
    logic [LOAD_W-1:0]   load_needed;
    logic                soft_limit;
    logic                last_site;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic              found;
    logic [TYPE_W-1:0] chosen_type;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;  // write one zero entry of the site mask memory
    logic load;    // capture a request and start its mask read
    logic exec;    // carry out the held request and load the result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
  } dp_stat_t;

  typedef struct packed {
    logic              found;
    logic [TYPE_W-1:0] index;
  } pick_t;

  // Lowest set bit of a type vector
  function automatic pick_t first_set(input logic [MASK_W-1:0] v);
    pick_t p;
    p.found = 1'b0;
    p.index = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        p.found = 1'b1;
        p.index = TYPE_W'(i);
      end
    end
    return p;
  endfunction

endpackage

### sv/vtffa_ctrl.sv
// ----------------------------------------------------------------------------
// vtffa_ctrl
// Request sequencer: clearing pass, accept, execute, output handshake.
// ----------------------------------------------------------------------------
module vtffa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vtffa_pkg::ctrl_cmd_t cmd,
  input  vtffa_pkg::dp_stat_t  stat
);
  import vtffa_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   go;
  logic   accept;

  // Result register free, or being emptied this cycle
  assign go       = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_EXEC) && go);
  assign accept   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.clr_en = (state_r == S_CLEAR);
    cmd.load   = accept;
    cmd.exec   = (state_r == S_EXEC) && go;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (go && !accept) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/vtffa_dp.sv
// ----------------------------------------------------------------------------
// vtffa_dp
// Type tables, site mask memory, query mask, type chooser, result register.
// ----------------------------------------------------------------------------
module vtffa_dp #(
  parameter int NUM_TYPES  = vtffa_pkg::DEF_NUM_TYPES,
  parameter int NUM_SITES  = vtffa_pkg::DEF_NUM_SITES,
  parameter int COUNT_BITS = vtffa_pkg::DEF_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vtffa_pkg::ctrl_cmd_t cmd,
  output vtffa_pkg::dp_stat_t  stat,
  input  vtffa_pkg::in_item_t  in_item,
  output vtffa_pkg::out_item_t out_item
);
  import vtffa_pkg::*;

  // Only the types and sites that the request fields can address are stored
  localparam int TYPES_USED = (NUM_TYPES < MASK_W) ? NUM_TYPES : MASK_W;
  localparam int TYPE_AW    = (TYPES_USED > 1) ? $clog2(TYPES_USED) : 1;
  localparam int SITE_DEPTH = (NUM_SITES < (1 << SITE_W)) ? NUM_SITES : (1 << SITE_W);
  localparam int SITE_AW    = (SITE_DEPTH > 1) ? $clog2(SITE_DEPTH) : 1;
  localparam logic [COUNT_BITS-1:0] UNLIMITED = '1;

  // Held request
  in_item_t item_r;
  logic     site_ok_r;

  // Site mask memory and its read path
  logic [MASK_W-1:0]  mask_mem [SITE_DEPTH];
  logic [MASK_W-1:0]  rd_r;
  logic               byp_r;
  logic [MASK_W-1:0]  byp_data_r;
  logic [SITE_AW-1:0] clr_addr_r;
  logic               we;
  logic [SITE_AW-1:0] waddr;
  logic [MASK_W-1:0]  wdata;
  logic [SITE_AW-1:0] raddr;
  logic [MASK_W-1:0]  site_mask;

  // Type tables
  logic [CAP_W-1:0]      cap_r [TYPES_USED];
  logic [COUNT_BITS-1:0] cnt_r [TYPES_USED];
  logic                  tw_cap_en;
  logic                  tw_cnt_en;
  logic [COUNT_BITS-1:0] tw_cnt;
  logic [TYPE_AW-1:0]    t_idx;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic                  type_ok;

  // Query
  logic [MASK_W-1:0] qmask_r, qmask_nxt;
  logic [MASK_W-1:0] qmask_all;
  logic [MASK_W-1:0] hard_v;
  logic [MASK_W-1:0] soft_v;
  pick_t             pick_hard;
  pick_t             pick_soft;
  out_item_t         result;

  // ---------------- clearing pass ----------------
  assign stat.clr_done = (clr_addr_r == SITE_AW'(SITE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_en && !stat.clr_done) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // ---------------- request capture ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r    <= in_item;
      site_ok_r <= (32'(in_item.site_index) < NUM_SITES);
    end
  end

  // ---------------- site mask memory ----------------
  assign raddr = in_item.site_index[SITE_AW-1:0];

  always_comb begin
    if (cmd.clr_en) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wdata = '0;
    end else begin
      we    = cmd.exec && (item_r.command == CMD_LOAD_MASK) && site_ok_r;
      waddr = item_r.site_index[SITE_AW-1:0];
      wdata = item_r.forbid_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mask_mem[waddr] <= wdata;
    if (cmd.load) rd_r <= mask_mem[raddr];
  end

  // Forward a mask written in the same cycle as the read of that site
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byp_r      <= we && (waddr == raddr);
      byp_data_r <= wdata;
    end
  end

  always_comb begin
    site_mask = byp_r ? byp_data_r : rd_r;
    if (!site_ok_r) site_mask = '0;
  end

  // ---------------- type tables ----------------
  assign type_ok = (32'(item_r.type_index) < NUM_TYPES);
  assign t_idx   = item_r.type_index[TYPE_AW-1:0];
  assign cur_cnt = cnt_r[t_idx];

  // ---------------- chooser ----------------
  assign qmask_all = qmask_r | site_mask;

  always_comb begin
    hard_v = '0;
    soft_v = '0;
    for (int t = 0; t < TYPES_USED; t++) begin
      soft_v[t] = (cnt_r[t] != '0) && !qmask_all[t];
      hard_v[t] = soft_v[t] &&
                  (item_r.load_needed <= {cap_r[t], {FRAC_BITS{1'b0}}});
    end
  end

  assign pick_hard = first_set(hard_v);
  assign pick_soft = first_set(soft_v);

  // ---------------- execute ----------------
  always_comb begin
    tw_cap_en = 1'b0;
    tw_cnt_en = 1'b0;
    tw_cnt    = COUNT_BITS'(item_r.count_value);
    qmask_nxt = qmask_r;
    result    = '0;
    case (item_r.command)
      CMD_LOAD_TYPE: begin
        tw_cap_en = type_ok;
        tw_cnt_en = type_ok;
      end
      CMD_RELEASE: begin
        tw_cnt    = cur_cnt + 1'b1;
        tw_cnt_en = type_ok && (cur_cnt != UNLIMITED);
      end
      CMD_RESERVE: begin
        tw_cnt = cur_cnt - 1'b1;
        if (type_ok) begin
          if (cur_cnt == '0) begin
            result.status = 1'b1;
          end else if (cur_cnt != UNLIMITED) begin
            tw_cnt_en = 1'b1;
          end
        end
      end
      CMD_QUERY: begin
        qmask_nxt = qmask_all;
        if (item_r.last_site) begin
          qmask_nxt = '0;
          if (pick_hard.found) begin
            result.found       = 1'b1;
            result.chosen_type = pick_hard.index;
          end else if (item_r.soft_limit && pick_soft.found) begin
            result.found       = 1'b1;
            result.chosen_type = pick_soft.index;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < TYPES_USED; t++) begin
        cap_r[t] <= '0;
        cnt_r[t] <= '0;
      end
      qmask_r <= '0;
    end else if (cmd.exec) begin
      if (tw_cap_en) cap_r[t_idx] <= item_r.capacity_value;
      if (tw_cnt_en) cnt_r[t_idx] <= tw_cnt;
      qmask_r <= qmask_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (cmd.exec) out_item <= result;
  end

endmodule

### sv/vehicle_type_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// vehicle_type_first_fit_allocator
// First-fit vehicle type allocator with per-site forbidden type masks.
// ----------------------------------------------------------------------------
// Every request returns exactly one result. A request is accepted, then
// executed once its site mask read (registered memory output) is available
// and the result register is free; its result is written to the output
// register as it executes, which raises out_valid. The next request is
// taken in the same cycle the previous one executes, so the block
// sustains one request per cycle as long as results are taken; a
// stalled result holds the request behind it. After reset the block runs a
// clearing pass over the site mask memory, one entry per cycle, over
// min(NUM_SITES, 1024) entries (1024 by default), with in_ready low.
module vehicle_type_first_fit_allocator #(
  parameter int NUM_TYPES  = vtffa_pkg::DEF_NUM_TYPES,
  parameter int NUM_SITES  = vtffa_pkg::DEF_NUM_SITES,
  parameter int COUNT_BITS = vtffa_pkg::DEF_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  vtffa_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output vtffa_pkg::out_item_t out_data
);
  import vtffa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  vtffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  vtffa_dp #(
    .NUM_TYPES  (NUM_TYPES),
    .NUM_SITES  (NUM_SITES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_item  (in_data),
    .out_item (out_data)
  );

endmodule

### sv/vtffa_checker.sv
// ----------------------------------------------------------------------------
// vtffa_checker
// Port-level checks for the vehicle type allocator, bound to the top level.
// ----------------------------------------------------------------------------
module vtffa_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input vtffa_pkg::out_item_t out_data
);
  import vtffa_pkg::*;

  // No result is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The clearing pass blocks requests right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request accepted during clearing pass");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A request in flight behind a stalled result blocks the input
  a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 (out_valid && !out_ready) |-> !in_ready)
    else $error("request accepted while result register is blocked");

  // A status error never comes with a found type
  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> !out_data.found && (out_data.chosen_type == '0))
    else $error("error status with a chosen type");

endmodule

bind vehicle_type_first_fit_allocator vtffa_checker u_vtffa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### sim/vehicle_type_first_fit_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vehicle_type_first_fit_allocator_tb
// Self-checking bench for the first-fit vehicle type allocator.
// ----------------------------------------------------------------------------
// Directed requests cover empty and unlimited counts, release saturation,
// fully forbidden sites and exact capacity fits. Random traffic follows;
// query runs of one to four sites are its most common kind, with table updates interleaved. A local
// predictor of the type and mask tables produces one expected result per
// accepted request, and every delivered result is checked field by field.
// Random gaps and stalls are applied on both channels.
// ----------------------------------------------------------------------------
module vehicle_type_first_fit_allocator_tb;
  import vtffa_pkg::*;

  localparam logic [CNT_IN_W-1:0] CNT_UNLIMITED   = '1;
  localparam logic [CMD_W-1:0]    CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0]    CMD_SPARE_LAST  = 3'd7;
  localparam int                  RANDOM_ITEMS    = 600;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_req = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_res;

  // Predictor state
  logic [CAP_W-1:0]    type_cap    [DEF_NUM_TYPES];
  logic [CNT_IN_W-1:0] type_avail  [DEF_NUM_TYPES];
  logic [MASK_W-1:0]   site_forbid [DEF_NUM_SITES];
  logic [MASK_W-1:0]   query_forbid;

  out_item_t alloc_expect_q [$];
  out_item_t want_res;
  bit        no_idle = 1'b0;
  int        errors = 0;
  int        reqs_sent = 0;
  int        results_seen = 0;
  int        placements = 0;
  int        empty_reserves = 0;

  vehicle_type_first_fit_allocator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_res)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (no_idle) return 0;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Apply one request to the tables and return its result
  function automatic out_item_t predict_alloc(input in_item_t r);
    out_item_t res;
    logic      fits;
    res = '0;
    case (r.command)
      CMD_LOAD_TYPE: begin
        type_cap[r.type_index]   = r.capacity_value;
        type_avail[r.type_index] = r.count_value;
      end
      CMD_LOAD_MASK: site_forbid[r.site_index] = r.forbid_mask;
      CMD_RELEASE: begin
        if (type_avail[r.type_index] != CNT_UNLIMITED)
          type_avail[r.type_index] = type_avail[r.type_index] + 1'b1;
      end
      CMD_RESERVE: begin
        if (type_avail[r.type_index] == '0)
          res.status = 1'b1;
        else if (type_avail[r.type_index] != CNT_UNLIMITED)
          type_avail[r.type_index] = type_avail[r.type_index] - 1'b1;
      end
      CMD_QUERY: begin
        query_forbid = query_forbid | site_forbid[r.site_index];
        if (r.last_site) begin
          // strict pass on capacity first, then the soft fallback
          for (int relax = 0; relax < 2; relax++) begin
            for (int t = 0; t < DEF_NUM_TYPES; t++) begin
              fits = ({type_cap[t], {FRAC_BITS{1'b0}}} >= r.load_needed);
              if (!res.found && (relax == 0 || r.soft_limit) && type_avail[t] != '0 &&
                  !query_forbid[t] && (relax == 1 || fits)) begin
                res.found       = 1'b1;
                res.chosen_type = TYPE_W'(t);
              end
            end
          end
          query_forbid = '0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t random_req(input logic [CMD_W-1:0] cmd);
    in_item_t r;
    r.command        = cmd;
    r.type_index     = TYPE_W'($urandom);
    r.site_index     = SITE_W'($urandom);
    r.capacity_value = CAP_W'($urandom);
    r.count_value    = CNT_IN_W'($urandom);
    r.forbid_mask    = MASK_W'($urandom);
    r.load_needed    = LOAD_W'($urandom);
    r.soft_limit     = 1'($urandom);
    r.last_site      = 1'($urandom);
    return r;
  endfunction

  function automatic logic [SITE_W-1:0] pick_site();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return SITE_W'($urandom_range(15));
    if (roll < 80) return $urandom_range(1) ? '0 : '1;
    return SITE_W'($urandom);
  endfunction

  function automatic logic [CAP_W-1:0] pick_cap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return CAP_W'($urandom_range(1000));
    if (roll < 60) return $urandom_range(1) ? '0 : '1;
    return CAP_W'($urandom);
  endfunction

  function automatic logic [CNT_IN_W-1:0] pick_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return CNT_IN_W'($urandom_range(3));
    if (roll < 55) return CNT_UNLIMITED;
    if (roll < 65) return CNT_UNLIMITED - 1'b1;
    return CNT_IN_W'($urandom);
  endfunction

  function automatic logic [LOAD_W-1:0] pick_need();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return LOAD_W'($urandom_range(1000 * 256));
    if (roll < 60) return $urandom_range(1) ? '0 : '1;
    return LOAD_W'($urandom);
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return '0;
    if (roll < 80) return MASK_W'(1) << $urandom_range(MASK_W - 1);
    return MASK_W'($urandom);
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_req(input in_item_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    alloc_expect_q.push_back(predict_alloc(req));
    reqs_sent++;
  endtask

  task automatic send_type_op(input logic [CMD_W-1:0] cmd, input int t);
    in_item_t r;
    r = random_req(cmd);
    r.type_index = TYPE_W'(t);
    send_req(r);
  endtask

  task automatic send_type_load(input int t, input logic [CAP_W-1:0] cap,
                                input logic [CNT_IN_W-1:0] cnt);
    in_item_t r;
    r = random_req(CMD_LOAD_TYPE);
    r.type_index     = TYPE_W'(t);
    r.capacity_value = cap;
    r.count_value    = cnt;
    send_req(r);
  endtask

  task automatic send_mask_load(input logic [SITE_W-1:0] site, input logic [MASK_W-1:0] m);
    in_item_t r;
    r = random_req(CMD_LOAD_MASK);
    r.site_index  = site;
    r.forbid_mask = m;
    send_req(r);
  endtask

  task automatic send_query(input logic [SITE_W-1:0] site, input logic last,
                            input logic [LOAD_W-1:0] need, input logic soft_en);
    in_item_t r;
    r = random_req(CMD_QUERY);
    r.site_index  = site;
    r.last_site   = last;
    r.load_needed = need;
    r.soft_limit  = soft_en;
    send_req(r);
  endtask

  // Hold off the sender until every result is back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (alloc_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_block();
    send_type_op(CMD_RESERVE, 0);
    send_query('0, 1'b1, '0, 1'b1);
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
      send_req(random_req(CMD_W'(c)));
  endtask

  task automatic test_count_edges();
    send_type_load(7, '1, CNT_UNLIMITED);
    send_type_op(CMD_RESERVE, 7);
    send_type_op(CMD_RELEASE, 7);
    send_type_load(3, '0, CNT_UNLIMITED - 1'b1);
    send_type_op(CMD_RELEASE, 3);
    send_type_op(CMD_RELEASE, 3);
    send_type_op(CMD_RESERVE, 3);
    send_type_load(1, CAP_W'(1), CNT_IN_W'(1));
    send_type_op(CMD_RESERVE, 1);
    send_type_op(CMD_RESERVE, 1);
  endtask

  task automatic test_query_edges();
    send_mask_load('1, '1);
    send_mask_load('0, MASK_W'(1) << 7);
    send_query('1, 1'b1, '0, 1'b1);
    send_query('0, 1'b1, {{CAP_W{1'b1}}, {FRAC_BITS{1'b0}}}, 1'b0);
    // two-site run with an update in the middle; soft fallback picks
    send_query(SITE_W'(5), 1'b0, '0, 1'b0);
    send_type_op(CMD_RESERVE, 0);
    send_query('0, 1'b1, '1, 1'b1);
    // exact capacity match
    send_query(SITE_W'(7), 1'b1, {{CAP_W{1'b1}}, {FRAC_BITS{1'b0}}}, 1'b0);
    send_query(SITE_W'(9), 1'b1, '0, 1'b0);
  endtask

  task automatic test_random_traffic(input int n_items, input bit burst);
    int       target;
    int       roll;
    int       n_sites;
    in_item_t r;
    target  = reqs_sent + n_items;
    no_idle = burst;
    while (reqs_sent < target) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        n_sites = $urandom_range(4, 1);
        for (int s = 0; s < n_sites; s++) begin
          send_query(pick_site(), s == n_sites - 1, pick_need(), 1'($urandom));
          if (s != n_sites - 1 && $urandom_range(99) < 15)
            send_type_op($urandom_range(1) ? CMD_RELEASE : CMD_RESERVE, $urandom_range(7));
        end
      end else if (roll < 55) begin
        send_type_load($urandom_range(7), pick_cap(), pick_count());
      end else if (roll < 67) begin
        send_mask_load(pick_site(), pick_mask());
      end else if (roll < 79) begin
        send_type_op(CMD_RELEASE, $urandom_range(7));
      end else if (roll < 93) begin
        send_type_op(CMD_RESERVE, $urandom_range(7));
      end else if (roll < 96) begin
        send_req(random_req(CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST))));
      end else begin
        // raw noise, including stray query ends
        send_req(random_req(CMD_W'($urandom)));
      end
    end
    no_idle = 1'b0;
  endtask

  // Result sink pacing
  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (alloc_expect_q.size() == 0) begin
        $error("result with no request pending: status %0d found %0d chosen_type %0d",
               out_res.status, out_res.found, out_res.chosen_type);
        errors++;
      end else begin
        want_res = alloc_expect_q.pop_front();
        placements     += want_res.found;
        empty_reserves += want_res.status;
        if (out_res.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, out_res.status);
          errors++;
        end
        if (out_res.found !== want_res.found) begin
          $error("found: expected %0d, got %0d", want_res.found, out_res.found);
          errors++;
        end
        if (out_res.chosen_type !== want_res.chosen_type) begin
          $error("chosen_type: expected %0d, got %0d",
                 want_res.chosen_type, out_res.chosen_type);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int t = 0; t < DEF_NUM_TYPES; t++) begin
      type_cap[t]   = '0;
      type_avail[t] = '0;
    end
    for (int s = 0; s < DEF_NUM_SITES; s++)
      site_forbid[s] = '0;
    query_forbid = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_block();
    test_count_edges();
    test_query_edges();
    test_random_traffic(200, 1'b0);
    wait_results_drained();
    test_random_traffic(100, 1'b1);
    test_random_traffic(RANDOM_ITEMS - 300, 1'b0);

    wait_results_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d requests (directed edges, random query runs, noise); checked %0d results.",
             reqs_sent, results_seen);
    $display("Queries placing a type: %0d, reserves on an empty type: %0d.",
             placements, empty_reserves);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
